/* rtl/core/dido_pkg.sv */
// Shared types, constants and a helper function for the dual IMU odometry block.
package dido_pkg;

  // Mode codes of an input word.
  localparam logic [1:0] MODE_TRACK  = 2'd0;
  localparam logic [1:0] MODE_ZERO   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam int MAX_STEPS = 24;

  // CORDIC gain in Q30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Arctangent table as a fraction of a full turn, 32 fractional bits.
  localparam logic [31:0] ATAN_TURN32 [MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721, 32'd20860,
    32'd10430, 32'd5215, 32'd2607, 32'd1303, 32'd651, 32'd325, 32'd162, 32'd81
  };

  // Results handed from the CORDIC unit to the sequencer.
  typedef struct packed {
    logic               done;
    logic signed [15:0] cos_q14;
    logic signed [15:0] sin_q14;
  } cordic_res_t;

  // Circular mean of two binary angles.
  function automatic logic [15:0] circ_mean(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] d;
    begin
      d = b - a;
      if (d == 16'h8000) circ_mean = 16'h8000;
      else circ_mean = a + {d[15], d[15:1]};
    end
  endfunction

endpackage

/* rtl/core/dual_imu_differential_odometry_unit.sv */
// Top level of the dual IMU differential odometry block.
// One input word on s_axis carries a mode and a sensor tick; one result word
// leaves on m_axis for every input word, in order.
// Track words fuse the two headings, form the encoder deltas, run the CORDIC
// unit and then use one 33x16 multiplier twice, first for X and then for Y.
// A track word passes the CORDIC wait, X multiply, Y multiply and Y accumulate
// states before the output state; zero and clear words go straight to it.
// s_axis_tready is high only while the block is idle with an empty output, so
// a new word can be taken from the cycle after the previous result is accepted.
// When the receiver stalls, the result stays in the output register and the
// block waits. Synchronous reset clears the heading offset, position and
// last averages and empties the output.
module dual_imu_differential_odometry_unit import dido_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: left_heading[15:0], right_heading[31:16], left_front_count[63:32],
  // left_back_count[95:64], right_front_count[127:96], right_back_count[159:128]
  input  logic [159:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,  // tuser: mode[1:0]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: heading[15:0], pos_x[63:16], pos_y[111:64], delta_left[143:112],
  // delta_right[175:144]
  output logic [175:0] m_axis_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_WAIT = 3'd1;
  localparam logic [2:0] ST_MULX = 3'd2;
  localparam logic [2:0] ST_MULY = 3'd3;
  localparam logic [2:0] ST_ACCY = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]         state;
  logic [15:0]        heading_offset;
  logic signed [47:0] x_accum, y_accum;
  logic signed [31:0] last_left_avg, last_right_avg;
  logic [15:0]        heading;
  logic signed [31:0] delta_left, delta_right;
  logic signed [32:0] dsum;
  logic signed [15:0] sin_hold;
  logic signed [49:0] prod;
  logic               cstart;
  cordic_res_t        cres;

  logic accept;
  logic [1:0] mode;
  logic signed [32:0] la_sum, ra_sum, la, ra;
  logic signed [33:0] dl_w, dr_w;
  logic signed [31:0] dl_s, dr_s;
  logic [15:0] h_track;
  logic signed [15:0] mul_c;
  logic signed [49:0] mul_p;
  logic signed [48:0] acc_in, acc_sum;
  logic signed [47:0] acc_sat;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;
  assign mode          = s_axis_tuser;

  // Encoder averages with truncation toward zero, and saturated deltas.
  always_comb begin
    la_sum = 33'($signed(s_axis_tdata[63:32])) + 33'($signed(s_axis_tdata[95:64]));
    ra_sum = 33'($signed(s_axis_tdata[127:96])) + 33'($signed(s_axis_tdata[159:128]));
    la = (la_sum + $signed({32'd0, la_sum[32] & la_sum[0]})) >>> 1;
    ra = (ra_sum + $signed({32'd0, ra_sum[32] & ra_sum[0]})) >>> 1;
    dl_w = 34'(la) - 34'(last_left_avg);
    dr_w = 34'(ra) - 34'(last_right_avg);
    dl_s = (dl_w > 34'sd2147483647) ? 32'sh7fffffff :
           (dl_w < -34'sd2147483648) ? 32'sh80000000 : 32'(dl_w);
    dr_s = (dr_w > 34'sd2147483647) ? 32'sh7fffffff :
           (dr_w < -34'sd2147483648) ? 32'sh80000000 : 32'(dr_w);
    h_track = circ_mean(s_axis_tdata[15:0] - heading_offset,
                        s_axis_tdata[31:16] - heading_offset);
  end

  // Shared multiplier and saturating accumulator.
  always_comb begin
    mul_c   = (state == ST_MULX) ? cres.cos_q14 : sin_hold;
    mul_p   = 50'(dsum) * 50'(mul_c);
    acc_in  = (state == ST_MULY) ? 49'(x_accum) : 49'(y_accum);
    acc_sum = acc_in + 49'(prod <<< 1);
    if (prod > 50'sd140737488355327 || acc_sum > 49'sd140737488355327)
      acc_sat = 48'sh7fffffffffff;
    else if (prod < -50'sd140737488355328 || acc_sum < -49'sd140737488355328)
      acc_sat = 48'sh800000000000;
    else acc_sat = 48'(acc_sum);
  end

  always_comb cstart = accept && (mode == MODE_TRACK);

  dido_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(h_track), .res(cres)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      m_axis_tvalid  <= 1'b0;
      heading_offset <= '0;
      x_accum        <= '0;
      y_accum        <= '0;
      last_left_avg  <= '0;
      last_right_avg <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (mode == MODE_TRACK) begin
              heading        <= h_track;
              delta_left     <= dl_s;
              delta_right    <= dr_s;
              dsum           <= 33'(dl_s) + 33'(dr_s);
              last_left_avg  <= 32'(la);
              last_right_avg <= 32'(ra);
              state          <= ST_WAIT;
            end else begin
              heading     <= '0;
              delta_left  <= '0;
              delta_right <= '0;
              if (mode == MODE_ZERO)
                heading_offset <= circ_mean(s_axis_tdata[15:0], s_axis_tdata[31:16]);
              else if (mode == MODE_CLEAR) begin
                x_accum <= '0;
                y_accum <= '0;
              end
              state <= ST_OUT;
            end
          end
        end
        ST_WAIT: if (cres.done) state <= ST_MULX;
        ST_MULX: begin
          sin_hold <= cres.sin_q14;
          prod     <= mul_p;
          state    <= ST_MULY;
        end
        ST_MULY: begin
          x_accum <= acc_sat;
          prod    <= mul_p;
          state   <= ST_ACCY;
        end
        ST_ACCY: begin
          y_accum <= acc_sat;
          state   <= ST_OUT;
        end
        ST_OUT: begin
          m_axis_tvalid <= 1'b1;
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tdata = {delta_right, delta_left, y_accum, x_accum, heading};

  property p_no_accept_busy;
    @(posedge clk) disable iff (rst) (state != ST_IDLE) |-> !s_axis_tready;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");

  property p_hold_out;
    @(posedge clk) disable iff (rst) (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata));
  endproperty
  a_hold_out: assert property (p_hold_out) else $error("result changed under stall");

  property p_cordic_wait;
    @(posedge clk) disable iff (rst) cres.done |-> (state == ST_WAIT);
  endproperty
  a_cordic_wait: assert property (p_cordic_wait) else $error("stray cordic result");

endmodule

/* rtl/core/dido_cordic.sv */
// Iterative CORDIC rotation unit producing cos and sin of a binary angle in Q2.14.
module dido_cordic import dido_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int ANGLE_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] angle,
  output cordic_res_t res
);

  localparam int STEPS = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int ZW    = ANGLE_BITS + 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic              busy;
  logic [CW-1:0]     step;
  logic              flip;
  logic signed [33:0] x, y;
  logic signed [ZW-1:0] z;
  logic signed [ZW-1:0] z0, z1;
  logic              flip0;
  logic signed [ZW-1:0] tval;
  logic [32:0]       trnd;
  logic signed [33:0] xs, ys, xf, yf;
  logic signed [34:0] xr, yr;
  logic signed [18:0] xq, yq;

  // Angle conversion and folding into the right half plane.
  always_comb begin
    if (ANGLE_BITS >= 16) z0 = ZW'($signed({2'b00, angle}) <<< (ANGLE_BITS - 16));
    else z0 = ZW'({2'b00, angle} >> (16 - ANGLE_BITS));
    if (z0 >= ZW'(1 <<< (ANGLE_BITS - 1))) z0 = z0 - ZW'(1 <<< ANGLE_BITS);
    flip0 = 1'b0;
    z1 = z0;
    if (z0 > ZW'(1 <<< (ANGLE_BITS - 2))) begin
      z1 = z0 - ZW'(1 <<< (ANGLE_BITS - 1));
      flip0 = 1'b1;
    end else if (z0 < -ZW'(1 <<< (ANGLE_BITS - 2))) begin
      z1 = z0 + ZW'(1 <<< (ANGLE_BITS - 1));
      flip0 = 1'b1;
    end
  end

  // One rotation step of the shared shifter and adders, plus rounding and clamping of the result.
  always_comb begin
    trnd = ({1'b0, ATAN_TURN32[5'(step)]} + 33'(33'd1 << (31 - ANGLE_BITS)))
           >> (32 - ANGLE_BITS);
    tval = ZW'(trnd);
    xs   = x >>> step;
    ys   = y >>> step;
    xf   = flip ? -x : x;
    yf   = flip ? -y : y;
    xr   = (35'(xf) + 35'sd32768) >>> 16;
    yr   = (35'(yf) + 35'sd32768) >>> 16;
    xq   = (xr > 35'sd16384) ? 19'sd16384 : (xr < -35'sd16384) ? -19'sd16384 : 19'(xr);
    yq   = (yr > 35'sd16384) ? 19'sd16384 : (yr < -35'sd16384) ? -19'sd16384 : 19'(yr);
  end

  // Step sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      res.done <= 1'b0;
      step     <= '0;
    end else begin
      res.done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x    <= CORDIC_GAIN;
        y    <= '0;
        z    <= z1;
        flip <= flip0;
      end else if (busy) begin
        if (step == CW'(STEPS)) begin
          busy        <= 1'b0;
          res.done    <= 1'b1;
          res.cos_q14 <= 16'(xq);
          res.sin_q14 <= 16'(yq);
        end else begin
          step <= step + 1'b1;
          if (z >= 0) begin
            x <= x - ys; y <= y + xs; z <= z - tval;
          end else begin
            x <= x + ys; y <= y - xs; z <= z + tval;
          end
        end
      end
    end
  end

  property p_done_pulse;
    @(posedge clk) disable iff (rst) res.done |=> !res.done;
  endproperty
  a_done_pulse: assert property (p_done_pulse) else $error("done held");

  property p_done_idle;
    @(posedge clk) disable iff (rst) res.done |-> !busy;
  endproperty
  a_done_idle: assert property (p_done_idle) else $error("done while busy");

  property p_clamp;
    @(posedge clk) disable iff (rst) res.done |->
      (res.cos_q14 <= 16'sd16384 && res.cos_q14 >= -16'sd16384);
  endproperty
  a_clamp: assert property (p_clamp) else $error("cos out of range");

endmodule
